FILE: rtl/mpfb_pkg.sv
// ----------------------------------------------------------------------------
// Frame store engine package
// Opcode and color codes and the decoded command that travels from the
// front end to the memory sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfb_pkg;

   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_FILL  = 2'd1;
   localparam logic [1:0] OP_PLACE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [1:0] COLOR_WHITE   = 2'd0;
   localparam logic [1:0] COLOR_BLACK   = 2'd1;
   localparam logic [1:0] COLOR_INVERSE = 2'd2;
   localparam logic [1:0] COLOR_NONE    = 2'd3;

   localparam logic [1:0] CMD_RMW  = 2'd0;
   localparam logic [1:0] CMD_FILL = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_ZERO = 2'd3;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam int         PAGE_ROWS = 8;

   typedef struct packed {
      logic [1:0] kind;
      logic       invert;
      logic       second;
      logic [7:0] column;
      logic [7:0] page;
      logic [7:0] mask_a;
      logic [7:0] data_a;
      logic [7:0] mask_b;
      logic [7:0] data_b;
   } mpfb_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/mono_page_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// Monochrome page frame store engine
// Read path: with the engine idle, an accepted read beat passes the command
// queue, a store read and the result queue before it shows on the result side;
// an off-screen read skips the store read. The sequencer finishes each command
// before it takes the next: pixel draws and sprite bytes by read-modify-write
// on the single-read-port store, fills and inverts by a sweep of the store.
// Reset: a clearing sweep over all SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8)
// bytes blackens the store; requests queue up during it but are carried out
// only after it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_page_framebuffer_engine #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [1:0] req_opcode,
   input  wire logic [1:0] req_color,
   input  wire logic [7:0] req_column,
   input  wire logic [7:0] req_row,
   input  wire logic [7:0] req_sprite_byte,
   input  wire logic [3:0] req_valid_rows,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_read_data
);

   import mpfb_pkg::*;

   localparam int CMD_BITS = $bits(mpfb_cmd_type);

   mpfb_cmd_type        front_cmd;
   mpfb_cmd_type        back_cmd;
   logic [CMD_BITS-1:0] queue_head;
   logic                cmd_push;
   logic                cmd_full;
   logic                cmd_empty;
   logic                cmd_pop;
   logic                rsp_push;
   logic                rsp_full;
   logic [7:0]          rsp_data;

   mpfb_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_color       (req_color),
      .req_column      (req_column),
      .req_row         (req_row),
      .req_sprite_byte (req_sprite_byte),
      .req_valid_rows  (req_valid_rows),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd             (front_cmd)
   );

   mpfb_fifo #(
      .WIDTH (CMD_BITS),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (queue_head),
      .empty   (cmd_empty)
   );

   assign back_cmd = mpfb_cmd_type'(queue_head);

   mpfb_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   mpfb_fifo #(
      .WIDTH (8),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_data),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_read_data),
      .empty   (rsp_empty)
   );

endmodule

`default_nettype wire

FILE: rtl/mpfb_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mpfb_fifo.sv
// ----------------------------------------------------------------------------
// Register FIFO
// Small first-in first-out queue built from flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [IW-1:0]    wptr_ff, wptr_in;
   logic [IW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entries_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == LAST_IDX) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == LAST_IDX) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mpfb_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts request beats, clips them to the screen and turns them into
// byte-level memory commands for the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfb_front #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [1:0]           req_color,
   input  wire logic [7:0]           req_column,
   input  wire logic [7:0]           req_row,
   input  wire logic [7:0]           req_sprite_byte,
   input  wire logic [3:0]           req_valid_rows,
   input  wire logic                 cmd_full,
   output logic                      cmd_push,
   output mpfb_pkg::mpfb_cmd_type    cmd
);

   import mpfb_pkg::*;

   localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;

   function automatic logic [7:0] page_row_mask(input logic [5:0] p);
      logic [8:0] first;
      logic [8:0] left;
      logic [8:0] ones;
      first = {p, 3'b000};
      left  = 9'(SCREEN_HEIGHT) - first;
      ones  = (9'd1 << left[2:0]) - 9'd1;
      if (first >= 9'(SCREEN_HEIGHT)) begin
         return 8'h00;
      end else if (left >= 9'(PAGE_ROWS)) begin
         return BYTE_ONES;
      end else begin
         return ones[7:0];
      end
   endfunction

   logic        accept;
   logic        keep;
   logic        col_ok;
   logic        row_ok;
   logic [3:0]  sat_rows;
   logic [8:0]  low_mask;
   logic [15:0] mask16;
   logic [15:0] data16;
   logic [5:0]  page;
   logic [5:0]  page_next;
   logic [7:0]  mask_lo;
   logic [7:0]  mask_hi;
   logic        lo_en;
   logic        hi_en;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign cmd_push = accept && keep;

   always_comb begin
      col_ok    = {1'b0, req_column} < 9'(SCREEN_WIDTH);
      row_ok    = {1'b0, req_row} < 9'(SCREEN_HEIGHT);
      sat_rows  = (req_valid_rows > 4'd8) ? 4'd8 : req_valid_rows;
      low_mask  = (9'd1 << sat_rows) - 9'd1;
      mask16    = {8'h00, low_mask[7:0]} << req_row[2:0];
      data16    = {8'h00, req_sprite_byte & low_mask[7:0]} << req_row[2:0];
      page      = {1'b0, req_row[7:3]};
      page_next = page + 6'd1;
      mask_lo   = mask16[7:0] & page_row_mask(page);
      mask_hi   = mask16[15:8] & page_row_mask(page_next);
      lo_en     = col_ok && ({3'b000, page} < 9'(PAGE_COUNT)) && (mask_lo != 8'h00);
      hi_en     = col_ok && ({3'b000, page_next} < 9'(PAGE_COUNT)) && (mask_hi != 8'h00);

      cmd        = '0;
      cmd.column = req_column;
      keep       = 1'b0;

      unique case (req_opcode)
         OP_DRAW: begin
            cmd.kind   = CMD_RMW;
            cmd.page   = {2'b00, page};
            cmd.mask_a = 8'h01 << req_row[2:0];
            keep       = col_ok && row_ok && (req_color != COLOR_NONE);
            unique case (req_color)
               COLOR_WHITE:   cmd.data_a = BYTE_ONES;
               COLOR_BLACK:   cmd.data_a = 8'h00;
               COLOR_INVERSE: cmd.invert = 1'b1;
               default:       cmd.data_a = 8'h00;
            endcase
         end
         OP_FILL: begin
            cmd.kind   = CMD_FILL;
            keep       = (req_color != COLOR_NONE);
            cmd.invert = (req_color == COLOR_INVERSE);
            cmd.data_a = (req_color == COLOR_WHITE) ? BYTE_ONES : 8'h00;
         end
         OP_PLACE: begin
            cmd.kind = CMD_RMW;
            keep     = lo_en || hi_en;
            if (lo_en) begin
               cmd.page   = {2'b00, page};
               cmd.mask_a = mask_lo;
               cmd.data_a = data16[7:0];
               cmd.second = hi_en;
               cmd.mask_b = mask_hi;
               cmd.data_b = data16[15:8];
            end else begin
               cmd.page   = {2'b00, page_next};
               cmd.mask_a = mask_hi;
               cmd.data_a = data16[15:8];
            end
         end
         OP_READ: begin
            keep     = 1'b1;
            cmd.page = req_row;
            if (col_ok && ({1'b0, req_row} < 9'(PAGE_COUNT))) begin
               cmd.kind = CMD_READ;
            end else begin
               cmd.kind = CMD_ZERO;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/mpfb_back.sv
// ----------------------------------------------------------------------------
// Back end
// Memory sequencer that owns the frame store: clearing sweep after reset,
// byte read-modify-write, whole-store fill and invert, and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module mpfb_back #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mpfb_pkg::mpfb_cmd_type cmd,
   input  wire logic                   cmd_empty,
   output logic                        cmd_pop,
   input  wire logic                   rsp_full,
   output logic                        rsp_push,
   output logic [7:0]                  rsp_data
);

   import mpfb_pkg::*;

   localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
   localparam int AW         = $clog2(STORE_SIZE);
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);
   localparam logic [AW-1:0] PAGE_STEP = AW'(SCREEN_WIDTH);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RMW   = 3'd2;
   localparam logic [2:0] ST_FILL  = 3'd3;
   localparam logic [2:0] ST_INV   = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   mpfb_cmd_type  cur_ff, cur_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic [15:0]   head_wide;
   logic [AW-1:0] head_addr;
   logic [7:0]    merged;

   assign head_wide = 16'(cmd.page) * 16'(SCREEN_WIDTH) + 16'(cmd.column);
   assign head_addr = head_wide[AW-1:0];
   assign merged    = cur_ff.invert ? (ram_rdata ^ cur_ff.mask_a)
                    : ((ram_rdata & ~cur_ff.mask_a) | (cur_ff.data_a & cur_ff.mask_a));

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      cur_in    = cur_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp_data  = ram_rdata;
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = 8'h00;
      ram_raddr = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd.kind)
                  CMD_RMW: begin
                     cmd_pop   = 1'b1;
                     cur_in    = cmd;
                     ram_raddr = head_addr;
                     addr_in   = head_addr;
                     state_in  = ST_RMW;
                  end
                  CMD_FILL: begin
                     cmd_pop   = 1'b1;
                     cur_in    = cmd;
                     ram_raddr = '0;
                     addr_in   = '0;
                     state_in  = cmd.invert ? ST_INV : ST_FILL;
                  end
                  CMD_READ: begin
                     if (!rsp_full) begin
                        cmd_pop   = 1'b1;
                        ram_raddr = head_addr;
                        state_in  = ST_READ;
                     end
                  end
                  CMD_ZERO: begin
                     if (!rsp_full) begin
                        cmd_pop  = 1'b1;
                        rsp_push = 1'b1;
                        rsp_data = 8'h00;
                     end
                  end
               endcase
            end
         end
         ST_RMW: begin
            ram_we    = 1'b1;
            ram_wdata = merged;
            if (cur_ff.second) begin
               ram_raddr     = addr_ff + PAGE_STEP;
               addr_in       = addr_ff + PAGE_STEP;
               cur_in.mask_a = cur_ff.mask_b;
               cur_in.data_a = cur_ff.data_b;
               cur_in.second = 1'b0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = cur_ff.data_a;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_INV: begin
            ram_we    = 1'b1;
            ram_wdata = ~ram_rdata;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               ram_raddr = addr_ff + 1'b1;
               addr_in   = addr_ff + 1'b1;
            end
         end
         ST_READ: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   mpfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !cmd_pop)
      else $error("Command taken during the clearing sweep.");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("Result pushed into a full result queue.");

   a_rmw_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RMW) |-> $past(state_ff == ST_IDLE || state_ff == ST_RMW))
      else $error("Merge write without a preceding read.");

   a_no_write_on_readout: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_READ) |-> !ram_we)
      else $error("Store written while idle or reading out.");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("Readout did not return to idle.");

endmodule

`default_nettype wire
